FILE: src/bdq_pkg.sv
package bdq_pkg;

    // Fixed field widths of the stream payload
    localparam int VALUE_W     = 32;
    localparam int MODE_W      = 3;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = MODE_W;
    localparam int OUT_TDATA_W = 80;

    // Parameter defaults
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_CLEAR      = 3'd4,
        MODE_QUERY      = 3'd5
    } t_mode;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_full;
        logic                is_empty;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  back_value;
        logic [VALUE_W-1:0]  front_value;
    } t_result;

endpackage

FILE: src/bdq_mem.sv
module bdq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bdq_ctrl.sv
module bdq_ctrl #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bdq_pkg::MODE_W-1:0] i_mode,
    input  logic [bdq_pkg::VALUE_W-1:0] i_value,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output bdq_pkg::t_result           o_res
);
    import bdq_pkg::*;

    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int AW      = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int SUM_W   = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [STORE_W-1:0] r_front, n_front;
    logic [STORE_W-1:0] r_back, n_back;
    logic [STATUS_W-1:0] r_status, n_status;
    logic               r_rd_front, n_rd_front;
    logic               r_rd_back, n_rd_back;

    logic               accept;
    logic               full, empty;
    logic [STORE_W-1:0] val;
    logic [SUM_W-1:0]   head_ext, cnt_ext, cap_ext;
    logic [SUM_W-1:0]   sum_tail, sum_inc, sum_last;
    logic [AW-1:0]      addr_tail, addr_inc, addr_last, addr_dec;
    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [STORE_W-1:0] rdata;
    logic [STORE_W-1:0] out_front, out_back;

    bdq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (STORE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (val),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);
    assign val     = STORE_W'(i_value);

    // Circular index math, each sum stays below twice the capacity
    assign head_ext = SUM_W'(r_head);
    assign cnt_ext  = SUM_W'(r_count);
    assign cap_ext  = SUM_W'(CAPACITY);
    assign sum_tail = head_ext + cnt_ext;
    assign sum_inc  = head_ext + SUM_W'(1);
    assign sum_last = head_ext + cnt_ext - SUM_W'(2);

    assign addr_tail = AW'((sum_tail >= cap_ext) ? sum_tail - cap_ext : sum_tail);
    assign addr_inc  = AW'((sum_inc  >= cap_ext) ? sum_inc  - cap_ext : sum_inc);
    assign addr_last = AW'((sum_last >= cap_ext) ? sum_last - cap_ext : sum_last);
    assign addr_dec  = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);

    // Operation decode and state update
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_front    = r_front;
        n_back     = r_back;
        n_status   = r_status;
        n_rd_front = r_rd_front;
        n_rd_back  = r_rd_back;
        we         = 1'b0;
        waddr      = addr_tail;
        re         = 1'b0;
        raddr      = addr_inc;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_READ;
                    n_status   = ST_OK;
                    n_rd_front = 1'b0;
                    n_rd_back  = 1'b0;
                    case (i_mode)
                        MODE_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_head  = addr_dec;
                                n_count = r_count + CNT_W'(1);
                                we      = 1'b1;
                                waddr   = addr_dec;
                                n_front = val;
                                if (empty) begin
                                    n_back = val;
                                end
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                we      = 1'b1;
                                waddr   = addr_tail;
                                n_back  = val;
                                if (empty) begin
                                    n_front = val;
                                end
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_head     = addr_inc;
                                n_count    = r_count - CNT_W'(1);
                                // new front comes from the entry after the old head
                                re         = (r_count != CNT_W'(1));
                                raddr      = addr_inc;
                                n_rd_front = (r_count != CNT_W'(1));
                            end
                        end
                        MODE_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_count   = r_count - CNT_W'(1);
                                re        = (r_count != CNT_W'(1));
                                raddr     = addr_last;
                                n_rd_back = (r_count != CNT_W'(1));
                            end
                        end
                        MODE_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        default: begin
                            // query and unused codes leave state alone
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                    n_front = out_front;
                    n_back  = out_back;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Cached end values and per-item flags
    always_ff @(posedge i_clk) begin
        r_front    <= n_front;
        r_back     <= n_back;
        r_status   <= n_status;
        r_rd_front <= n_rd_front;
        r_rd_back  <= n_rd_back;
    end

    // Result assembly; read data replaces the cached end that moved
    assign out_front = r_rd_front ? rdata : r_front;
    assign out_back  = r_rd_back  ? rdata : r_back;

    assign o_res_valid       = (r_state == S_READ);
    assign o_res.front_value = empty ? '0 : VALUE_W'(out_front);
    assign o_res.back_value  = empty ? '0 : VALUE_W'(out_back);
    assign o_res.count       = COUNT_W'(r_count);
    assign o_res.is_empty    = empty;
    assign o_res.is_full     = full;
    assign o_res.status      = r_status;

endmodule

FILE: src/bounded_deque_engine_core.sv
// Bounded double-ended queue on a circular buffer.
// Input stream (s_axis): one operation per transfer, mode in tuser, value in
// tdata. Output stream (m_axis): one result per operation, holding the front
// and back elements, the count, empty/full flags and a status code.
// The result passes through the controller's read state and the output
// register before it appears on m_axis; a new operation is taken only once
// the last result has left the read state. Each operation updates the
// pointers, makes at most one element RAM write or read and waits for the
// registered read to return the new end element. Front and back values are
// cached in registers, so a push needs no read and a pop reads at most one.
// Reset: head and count go to zero; RAM contents are not cleared and need
// no clearing pass, since only written entries are ever read.
// Stall: the result sits in an output register. The next operation is
// accepted while it waits; a second finished result holds in the core and
// s_axis_tready stays low until the output register frees.
module bounded_deque_engine_core #(
    parameter int CAPACITY   = bdq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bdq_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic [bdq_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // [2:0] mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] front_value, [63:32] back_value, [74:64] count, [75] is_empty,
    // [76] is_full, [78:77] status, [79] zero
    output logic [bdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bdq_pkg::*;

    logic    res_valid, res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    bdq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register frees when empty or when its transfer completes
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

FILE: src/bdq_chk.sv
module bdq_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bdq_pkg::*;

    t_result res;
    logic    in_xfer;

    assign res     = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // One operation in flight: no back-to-back input transfers
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // Empty flag agrees with the count and blanks both end values
    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.is_empty == (res.count == '0)) &&
            (!res.is_empty || (res.front_value == '0 && res.back_value == '0)))
        else $error("empty flag inconsistent with result");

    // A refused push leaves the deque full; a refused pop leaves it empty
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (res.status != ST_OVERFLOW || res.is_full) &&
            (res.status != ST_UNDERFLOW || res.is_empty))
        else $error("refusal status with wrong fill state");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind bounded_deque_engine_core bdq_chk u_bdq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
